// File: rtl/mfqs_pkg.sv
package mfqs_pkg;

  // defaults for the top level parameters
  localparam int unsigned ENTRY_COUNT_DEF = 64;
  localparam int unsigned MAX_LEVELS_DEF  = 8;

  // level_count register
  localparam logic [3:0] LEVEL_COUNT_RST  = 4'd4;
  localparam logic [2:0] ADDR_LEVEL_COUNT = 3'd0;

  // levels in use, 1..15, and the quantum, up to 29
  localparam int unsigned LVU_W = 5;
  localparam int unsigned QNT_W = 6;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_PICK   = 6'b000100,
    ST_WR_ARR = 6'b001000,
    ST_WR_DEM = 6'b010000,
    ST_FIN    = 6'b100000
  } state_e;

  // where the chosen job comes from
  typedef enum logic [1:0] {
    SRC_ENTRY   = 2'd0,
    SRC_ARRIVAL = 2'd1,
    SRC_DEMOTE  = 2'd2
  } src_e;

endpackage

// File: rtl/multilevel_feedback_queue_scheduler.sv
// Channel   Dir  Handshake                    Word
// tick      in   start_i && !busy_o           arrival_valid_i, job_priority_i, job_length_i
// result    out  result_valid_o (one cycle)   busy_res_o .. arrival_dropped_o
// config    in   APB, psel/penable/pwrite     level_count at byte address 0
//
// busy_o is high while a tick is processed: the entry store is one memory
// with a single read port, and every entry is read once per tick to pick the next job
// and the free slots. The result strobe is in the first cycle after busy_o falls, the
// cycle in which the next tick may be accepted.
// Reset clears the valid bits, the running job and all counters; store entries
// are not reset and are used only when valid. The receiver cannot stall results.
module multilevel_feedback_queue_scheduler #(
  parameter int unsigned ENTRY_COUNT = mfqs_pkg::ENTRY_COUNT_DEF,
  parameter int unsigned MAX_LEVELS  = mfqs_pkg::MAX_LEVELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        arrival_valid_i,
  input  logic [3:0]  job_priority_i,
  input  logic [15:0] job_length_i,
  output logic        result_valid_o,
  output logic        busy_res_o,
  output logic [2:0]  running_level_o,
  output logic        done_valid_o,
  output logic [3:0]  done_priority_o,
  output logic [31:0] done_waited_o,
  output logic [31:0] done_arrival_o,
  output logic [31:0] idle_ticks_o,
  output logic        arrival_dropped_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mfqs_pkg::*;

  localparam int unsigned AW  = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int unsigned CW  = $clog2(ENTRY_COUNT + 1);
  localparam int unsigned LVW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

  typedef struct packed {
    logic [LVW-1:0] lvl;
    logic [3:0]     pri;
    logic [15:0]    rem;
    logic [31:0]    w0;   // waited count when stored
    logic [31:0]    t0;   // tick when stored
    logic [31:0]    arr;
    logic [31:0]    ord;
  } entry_t;

  state_e state_q, state_d;
  logic [3:0] lc_q, lc_d;
  logic [ENTRY_COUNT-1:0] valid_q, valid_d;
  logic [CW-1:0] cnt_q, cnt_d, sc_q, sc_d;
  logic pv_q, pv_d;
  logic [AW-1:0] pidx_q, pidx_d;
  logic arr_q, arr_d, drop_q, drop_d, dec_q, dec_d, dem_q, dem_d, fin_q, fin_d;
  logic [3:0] pri_in_q, pri_in_d;
  logic [15:0] len_in_q, len_in_d;
  logic have_q, have_d;
  entry_t best_q, best_d;
  src_e bsrc_q, bsrc_d;
  logic [AW-1:0] bidx_q, bidx_d;
  logic [LVW-1:0] blv_q, blv_d;
  logic f1v_q, f1v_d, f2v_q, f2v_d;
  logic [AW-1:0] f1_q, f1_d, f2_q, f2_d;
  logic cur_v_q, cur_v_d;
  logic [LVW-1:0] cur_lvl_q, cur_lvl_d;
  logic [3:0] cur_pri_q, cur_pri_d;
  logic [15:0] cur_rem_q, cur_rem_d, run_q, run_d;
  logic [31:0] cur_w_q, cur_w_d, cur_arr_q, cur_arr_d;
  logic [31:0] idle_q, idle_d, tick_q, tick_d, ins_q, ins_d;
  logic res_v_q, res_v_d, busy_res_q, busy_res_d, done_v_q, done_v_d, dropo_q, dropo_d;
  logic [2:0] rlvl_q, rlvl_d;
  logic [3:0] dpri_q, dpri_d;
  logic [31:0] dwait_q, dwait_d, darr_q, darr_d;

  // entry store
  entry_t mem [ENTRY_COUNT];
  entry_t rd_q, wd;
  logic re, we;
  logic [AW-1:0] ra, wa;

  // derived level settings
  logic [LVU_W-1:0] lvu;
  logic [LVW-1:0] last;
  logic [QNT_W-1:0] quantum;
  logic [LVW:0] nl_w;
  logic [LVW-1:0] nl;
  entry_t ent_arr, ent_dem, ent_in;
  logic sel;
  logic [CW:0] used;
  logic [31:0] wdiff;
  logic [32:0] wsum;
  logic [15:0] run;

  function automatic logic [LVW-1:0] clip(input logic [LVW-1:0] l,
                                          input logic [LVW-1:0] lst);
    clip = (l > lst) ? lst : l;
  endfunction

  // a is served before b
  function automatic logic served(input logic [LVW-1:0] la, input entry_t a,
                                  input logic [LVW-1:0] lb, input entry_t b);
    logic r;
    if (la != lb)           r = la < lb;
    else if (la == '0)      r = a.ord > b.ord;
    else if (a.pri != b.pri) r = a.pri < b.pri;
    else                    r = a.ord < b.ord;
    served = r;
  endfunction

  always_comb begin
    if (lc_q == 4'd0) begin
      lvu = LVU_W'(1);
    end else if (LVU_W'(lc_q) > LVU_W'(MAX_LEVELS)) begin
      lvu = LVU_W'(MAX_LEVELS);
    end else begin
      lvu = LVU_W'(lc_q);
    end
  end
  assign last    = LVW'(lvu - LVU_W'(1));
  assign quantum = {1'b0, lvu} + {1'b0, lvu} - QNT_W'(1);

  // demotion target
  assign nl_w = (LVW + 1)'(cur_lvl_q) + (LVW + 1)'(1);
  assign nl   = (nl_w > {1'b0, last}) ? last : nl_w[LVW-1:0];

  assign ent_arr = '{lvl: '0, pri: pri_in_q, rem: len_in_q, w0: '0, t0: tick_q,
                     arr: tick_q, ord: ins_q};
  assign ent_dem = '{lvl: nl, pri: cur_pri_q, rem: cur_rem_q, w0: cur_w_q, t0: tick_q,
                     arr: cur_arr_q, ord: ins_q + 32'(arr_q)};
  assign ent_in  = '{lvl: '0, pri: job_priority_i,
                     rem: (job_length_i == 16'd0) ? 16'd1 : job_length_i,
                     w0: '0, t0: tick_q, arr: tick_q, ord: ins_q};

  assign sel   = !dec_q && have_q;
  assign used  = (CW + 1)'(cnt_q) + (CW + 1)'(cur_v_q);
  assign wdiff = tick_q - best_q.t0;
  assign wsum  = {1'b0, best_q.w0} + {1'b0, wdiff};

  // granted run of the chosen job
  always_comb begin
    run = best_q.rem;
    if (blv_q != last && best_q.rem > 16'(quantum)) run = 16'(quantum);
    if (run == 16'd0) run = 16'd1;
  end

  // tick sequencer
  always_comb begin
    state_d = state_q;   lc_d = lc_q;         valid_d = valid_q;  cnt_d = cnt_q;
    sc_d = sc_q;         pv_d = 1'b0;         pidx_d = pidx_q;
    arr_d = arr_q;       drop_d = drop_q;     dec_d = dec_q;      dem_d = dem_q;
    fin_d = fin_q;       pri_in_d = pri_in_q; len_in_d = len_in_q;
    have_d = have_q;     best_d = best_q;     bsrc_d = bsrc_q;
    bidx_d = bidx_q;     blv_d = blv_q;
    f1v_d = f1v_q;       f1_d = f1_q;         f2v_d = f2v_q;      f2_d = f2_q;
    cur_v_d = cur_v_q;   cur_lvl_d = cur_lvl_q; cur_pri_d = cur_pri_q;
    cur_rem_d = cur_rem_q; cur_w_d = cur_w_q; cur_arr_d = cur_arr_q;
    run_d = run_q;       idle_d = idle_q;     tick_d = tick_q;    ins_d = ins_q;
    res_v_d = 1'b0;      busy_res_d = busy_res_q; rlvl_d = rlvl_q;
    done_v_d = done_v_q; dpri_d = dpri_q;     dwait_d = dwait_q;  darr_d = darr_q;
    dropo_d = dropo_q;
    re = 1'b0;           ra = '0;
    we = 1'b0;           wa = '0;             wd = ent_arr;

    // configuration write
    if (psel && penable && pwrite && paddr == ADDR_LEVEL_COUNT) lc_d = pwdata[3:0];

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          drop_d   = arrival_valid_i && (used >= (CW + 1)'(ENTRY_COUNT));
          arr_d    = arrival_valid_i && !drop_d;
          pri_in_d = ent_in.pri;
          len_in_d = ent_in.rem;
          dec_d    = run_q != 16'd0;
          dem_d    = !dec_d && cur_v_q && cur_rem_q != 16'd0;
          fin_d    = !dec_d && cur_v_q && cur_rem_q == 16'd0;
          // the arrival is the first candidate
          have_d   = arr_d;
          best_d   = ent_in;
          bsrc_d   = SRC_ARRIVAL;
          blv_d    = '0;
          f1v_d    = 1'b0;
          f2v_d    = 1'b0;
          sc_d     = '0;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sc_q < CW'(ENTRY_COUNT)) begin
          re     = 1'b1;
          ra     = sc_q[AW-1:0];
          pidx_d = sc_q[AW-1:0];
          pv_d   = 1'b1;
          sc_d   = sc_q + CW'(1);
        end
        // compare the entry read last cycle
        if (pv_q) begin
          if (valid_q[pidx_q]) begin
            if (!have_q || served(clip(rd_q.lvl, last), rd_q, blv_q, best_q)) begin
              have_d = 1'b1;
              best_d = rd_q;
              bsrc_d = SRC_ENTRY;
              bidx_d = pidx_q;
              blv_d  = clip(rd_q.lvl, last);
            end
          end else if (!f1v_q) begin
            f1v_d = 1'b1;
            f1_d  = pidx_q;
          end else if (!f2v_q) begin
            f2v_d = 1'b1;
            f2_d  = pidx_q;
          end
        end
        if (sc_q == CW'(ENTRY_COUNT) && !pv_q) state_d = ST_PICK;
      end
      ST_PICK: begin
        if (dem_q && (!have_q || served(nl, ent_dem, blv_q, best_q))) begin
          have_d = 1'b1;
          best_d = ent_dem;
          bsrc_d = SRC_DEMOTE;
          blv_d  = nl;
        end
        state_d = ST_WR_ARR;
      end
      ST_WR_ARR: begin
        if (arr_q && !(sel && bsrc_q == SRC_ARRIVAL)) begin
          we = 1'b1;
          wa = f1_q;
          wd = ent_arr;
          valid_d[f1_q] = 1'b1;
        end
        state_d = ST_WR_DEM;
      end
      ST_WR_DEM: begin
        if (dem_q && !(sel && bsrc_q == SRC_DEMOTE)) begin
          we = 1'b1;
          wa = arr_q ? f2_q : f1_q;
          wd = ent_dem;
          valid_d[wa] = 1'b1;
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        ins_d = ins_q + 32'(arr_q) + 32'(dem_q);
        cnt_d = cnt_q + CW'(arr_q) + CW'(dem_q) - CW'(sel);
        if (dec_q) begin
          run_d = run_q - 16'd1;
        end else if (sel) begin
          if (bsrc_q == SRC_ENTRY) valid_d[bidx_q] = 1'b0;
          cur_v_d   = 1'b1;
          cur_lvl_d = blv_q;
          cur_pri_d = best_q.pri;
          cur_w_d   = wsum[32] ? 32'hFFFF_FFFF : wsum[31:0];
          cur_arr_d = best_q.arr;
          run_d     = run - 16'd1;
          cur_rem_d = (best_q.rem >= run) ? best_q.rem - run : 16'd0;
        end else begin
          cur_v_d   = 1'b0;
          cur_lvl_d = '0;
          if (idle_q != 32'hFFFF_FFFF) idle_d = idle_q + 32'd1;
        end
        // result word
        res_v_d    = 1'b1;
        busy_res_d = cur_v_d;
        rlvl_d     = cur_v_d ? 3'(cur_lvl_d) : 3'd0;
        done_v_d   = fin_q;
        dpri_d     = fin_q ? cur_pri_q : 4'd0;
        dwait_d    = fin_q ? cur_w_q : 32'd0;
        darr_d     = fin_q ? cur_arr_q : 32'd0;
        dropo_d    = drop_q;
        tick_d     = tick_q + 32'd1;
        state_d    = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;  lc_q <= LEVEL_COUNT_RST;  valid_q <= '0;  cnt_q <= '0;
      sc_q <= '0;          pv_q <= 1'b0;
      arr_q <= 1'b0;       drop_q <= 1'b0;  dec_q <= 1'b0;  dem_q <= 1'b0;  fin_q <= 1'b0;
      have_q <= 1'b0;      f1v_q <= 1'b0;   f2v_q <= 1'b0;
      cur_v_q <= 1'b0;     cur_lvl_q <= '0; cur_pri_q <= '0; cur_rem_q <= '0;
      cur_w_q <= '0;       cur_arr_q <= '0; run_q <= '0;
      idle_q <= '0;        tick_q <= '0;    ins_q <= '0;
      res_v_q <= 1'b0;     busy_res_q <= 1'b0; rlvl_q <= '0; done_v_q <= 1'b0;
      dpri_q <= '0;        dwait_q <= '0;   darr_q <= '0;   dropo_q <= 1'b0;
    end else begin
      state_q <= state_d;  lc_q <= lc_d;    valid_q <= valid_d;  cnt_q <= cnt_d;
      sc_q <= sc_d;        pv_q <= pv_d;
      arr_q <= arr_d;      drop_q <= drop_d; dec_q <= dec_d;  dem_q <= dem_d;  fin_q <= fin_d;
      have_q <= have_d;    f1v_q <= f1v_d;  f2v_q <= f2v_d;
      cur_v_q <= cur_v_d;  cur_lvl_q <= cur_lvl_d; cur_pri_q <= cur_pri_d;
      cur_rem_q <= cur_rem_d; cur_w_q <= cur_w_d; cur_arr_q <= cur_arr_d; run_q <= run_d;
      idle_q <= idle_d;    tick_q <= tick_d; ins_q <= ins_d;
      res_v_q <= res_v_d;  busy_res_q <= busy_res_d; rlvl_q <= rlvl_d; done_v_q <= done_v_d;
      dpri_q <= dpri_d;    dwait_q <= dwait_d; darr_q <= darr_d; dropo_q <= dropo_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pidx_q   <= pidx_d;
    pri_in_q <= pri_in_d;
    len_in_q <= len_in_d;
    best_q   <= best_d;
    bsrc_q   <= bsrc_d;
    bidx_q   <= bidx_d;
    blv_q    <= blv_d;
    f1_q     <= f1_d;
    f2_q     <= f2_d;
  end

  // store memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (re) rd_q <= mem[ra];
  end

  assign busy_o            = state_q != ST_IDLE;
  assign result_valid_o    = res_v_q;
  assign busy_res_o        = busy_res_q;
  assign running_level_o   = rlvl_q;
  assign done_valid_o      = done_v_q;
  assign done_priority_o   = dpri_q;
  assign done_waited_o     = dwait_q;
  assign done_arrival_o    = darr_q;
  assign idle_ticks_o      = idle_q;
  assign arrival_dropped_o = dropo_q;
  assign pready            = 1'b1;
  assign prdata            = (paddr == ADDR_LEVEL_COUNT) ? {28'd0, lc_q} : 32'd0;

  // checks
  a_res_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == ST_FIN))
    else $error("result word without a finished tick");
  a_store_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(ENTRY_COUNT))
    else $error("store count above capacity");
  a_level_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !busy_res_o) |-> running_level_o == 3'd0)
    else $error("running level set while idle");
  a_drop_no_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PICK) |-> !(arr_q && drop_q))
    else $error("arrival both stored and dropped");
  a_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR_ARR && arr_q) |-> f1v_q)
    else $error("no free slot for a stored arrival");
endmodule

// File: tb/sv/tb_multilevel_feedback_queue_scheduler.sv
`timescale 1ns / 100ps

// Scoreboard: holds a model of the scheduler state and the queue of expected result words
class mfqs_scoreboard;
  localparam int NENT = 64;
  localparam int MAXL = 8;

  bit          ent_vld [NENT];
  bit [2:0]    ent_lvl [NENT];
  bit [3:0]    ent_pri [NENT];
  bit [15:0]   ent_rem [NENT];
  bit [31:0]   ent_wait[NENT];
  bit [31:0]   ent_arr [NENT];
  bit [31:0]   ent_ord [NENT];

  bit          cur_vld;
  bit [31:0]   cur_lvl;
  bit [3:0]    cur_pri;
  bit [15:0]   cur_rem;
  bit [31:0]   cur_wait;
  bit [31:0]   cur_arr;
  bit [15:0]   run_left;
  bit [31:0]   idle_cnt;
  bit [31:0]   tick_cnt;
  bit [31:0]   ins_cnt;
  bit [3:0]    level_cnt;

  // one expected result word, packed
  typedef struct packed {
    logic        busy;
    logic [2:0]  lvl;
    logic        done;
    logic [3:0]  pri;
    logic [31:0] waited;
    logic [31:0] arrival;
    logic [31:0] idle;
    logic        dropped;
  } tick_word_t;

  tick_word_t pending_words[$];
  int errors;
  int n_done, n_drop, n_idle_words;

  function new();
    foreach (ent_vld[i]) ent_vld[i] = 0;
    cur_vld = 0; cur_lvl = 0; cur_pri = 0; cur_rem = 0; cur_wait = 0; cur_arr = 0;
    run_left = 0; idle_cnt = 0; tick_cnt = 0; ins_cnt = 0; level_cnt = 4'd4;
    errors = 0; n_done = 0; n_drop = 0; n_idle_words = 0;
  endfunction

  function void set_levels(bit [3:0] v);
    level_cnt = v;
  endfunction

  function int lowest_free();
    for (int i = 0; i < NENT; i++) if (!ent_vld[i]) return i;
    return -1;
  endfunction

  function void put_job(int s, bit [31:0] lvl, bit [3:0] pri, bit [15:0] rem,
                        bit [31:0] w, bit [31:0] a);
    ent_vld[s] = 1; ent_lvl[s] = lvl[2:0]; ent_pri[s] = pri; ent_rem[s] = rem;
    ent_wait[s] = w; ent_arr[s] = a; ent_ord[s] = ins_cnt;
    ins_cnt++;
  endfunction

  // a served ahead of b at level lvl
  function bit ahead_of(int a, int b, bit [31:0] lvl);
    if (lvl == 0) return ent_ord[a] > ent_ord[b];
    if (ent_pri[a] != ent_pri[b]) return ent_pri[a] < ent_pri[b];
    return ent_ord[a] < ent_ord[b];
  endfunction

  // note an accepted tick and queue its expected word
  function void note_tick(bit av, bit [3:0] pri, bit [15:0] len);
    bit [31:0] levels, last_lvl, quantum, used, nl, lv, best_lvl, run;
    int best, s;
    tick_word_t w;
    levels = (level_cnt == 0) ? 32'd1 : ((level_cnt > MAXL) ? 32'(MAXL) : 32'(level_cnt));
    last_lvl = levels - 1;
    quantum = 2 * levels - 1;
    w = '0;

    if (av) begin
      used = 32'(cur_vld);
      for (int i = 0; i < NENT; i++) used += 32'(ent_vld[i]);
      s = lowest_free();
      if (used >= NENT || s < 0) w.dropped = 1;
      else put_job(s, 0, pri, (len == 0) ? 16'd1 : len, 0, tick_cnt);
    end

    if (run_left == 0) begin
      best = -1; best_lvl = 0;
      if (cur_vld) begin
        if (cur_rem == 0) begin
          w.done = 1; w.pri = cur_pri; w.waited = cur_wait; w.arrival = cur_arr;
        end else begin
          nl = cur_lvl + 1;
          if (nl > last_lvl) nl = last_lvl;
          s = lowest_free();
          if (s >= 0) put_job(s, nl, cur_pri, cur_rem, cur_wait, cur_arr);
        end
        cur_vld = 0;
      end
      for (int i = 0; i < NENT; i++) begin
        if (ent_vld[i]) begin
          lv = 32'(ent_lvl[i]);
          if (lv > last_lvl) lv = last_lvl;
          if (best < 0 || lv < best_lvl || (lv == best_lvl && ahead_of(i, best, lv))) begin
            best = i; best_lvl = lv;
          end
        end
      end
      if (best < 0) begin
        if (idle_cnt != 32'hFFFF_FFFF) idle_cnt++;
        cur_lvl = 0;
      end else begin
        ent_vld[best] = 0;
        cur_pri = ent_pri[best]; cur_rem = ent_rem[best];
        cur_wait = ent_wait[best]; cur_arr = ent_arr[best];
        cur_lvl = best_lvl; cur_vld = 1;
        run = 32'(cur_rem);
        if (best_lvl != last_lvl && run > quantum) run = quantum;
        if (run == 0) run = 1;
        run_left = 16'(run - 1);
        cur_rem = (32'(cur_rem) >= run) ? 16'(32'(cur_rem) - run) : 16'd0;
      end
    end else begin
      run_left--;
    end

    for (int i = 0; i < NENT; i++)
      if (ent_vld[i] && ent_wait[i] != 32'hFFFF_FFFF) ent_wait[i]++;
    tick_cnt++;

    w.busy = cur_vld;
    w.lvl = cur_vld ? cur_lvl[2:0] : 3'd0;
    w.idle = idle_cnt;
    if (w.done) n_done++;
    if (w.dropped) n_drop++;
    if (!w.busy) n_idle_words++;
    pending_words.insert(pending_words.size(), w);
  endfunction

  // compare one result word with the oldest expectation
  function void check_word(tick_word_t got);
    tick_word_t exp_w;
    if (pending_words.size() == 0) begin
      $display("%0t: unexpected result word %h", $time, got);
      errors++;
      return;
    end
    exp_w = pending_words.pop_front();
    if (got.busy !== exp_w.busy)
      $display("%0t: busy_res exp %0d got %0d", $time, exp_w.busy, got.busy);
    if (got.lvl !== exp_w.lvl)
      $display("%0t: running_level exp %0d got %0d", $time, exp_w.lvl, got.lvl);
    if (got.done !== exp_w.done)
      $display("%0t: done_valid exp %0d got %0d", $time, exp_w.done, got.done);
    if (got.pri !== exp_w.pri)
      $display("%0t: done_priority exp %0d got %0d", $time, exp_w.pri, got.pri);
    if (got.waited !== exp_w.waited)
      $display("%0t: done_waited exp %0d got %0d", $time, exp_w.waited, got.waited);
    if (got.arrival !== exp_w.arrival)
      $display("%0t: done_arrival exp %0d got %0d", $time, exp_w.arrival, got.arrival);
    if (got.idle !== exp_w.idle)
      $display("%0t: idle_ticks exp %0d got %0d", $time, exp_w.idle, got.idle);
    if (got.dropped !== exp_w.dropped)
      $display("%0t: arrival_dropped exp %0d got %0d", $time, exp_w.dropped, got.dropped);
    if (got !== exp_w) errors++;
  endfunction
endclass

module tb_multilevel_feedback_queue_scheduler;
  import mfqs_pkg::*;

  logic        clk_i, rst_ni;
  logic        start_i, busy_o;
  logic        arrival_valid_i;
  logic [3:0]  job_priority_i;
  logic [15:0] job_length_i;
  logic        result_valid_o, busy_res_o, done_valid_o, arrival_dropped_o;
  logic [2:0]  running_level_o;
  logic [3:0]  done_priority_o;
  logic [31:0] done_waited_o, done_arrival_o, idle_ticks_o;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  mfqs_scoreboard sched_sb;
  bit quiet_sender;
  int n_ticks;

  multilevel_feedback_queue_scheduler dut (.*);

  // clock
  always begin
    clk_i = 1'b0; #10;
    clk_i = 1'b1; #10;
  end

  // result words checked at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o)
      sched_sb.check_word({busy_res_o, running_level_o, done_valid_o, done_priority_o,
                           done_waited_o, done_arrival_o, idle_ticks_o, arrival_dropped_o});
  end

  // APB write of level_count, setup then access
  task automatic write_levels(bit [3:0] v);
    @(negedge clk_i);
    psel = 1; penable = 0; pwrite = 1; paddr = ADDR_LEVEL_COUNT; pwdata = 32'(v);
    @(negedge clk_i);
    penable = 1;
    do @(posedge clk_i); while (!pready);
    sched_sb.set_levels(v);
    @(negedge clk_i);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  // wait for all expected words, then the tick latency
  task automatic drain();
    while (sched_sb.pending_words.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // drive one tick word and wait for its acceptance
  task automatic send_tick(bit av, bit [3:0] pri, bit [15:0] len);
    if (!quiet_sender && $urandom_range(0, 5) == 0) begin
      @(negedge clk_i);
      start_i = 0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i = 1; arrival_valid_i = av; job_priority_i = pri; job_length_i = len;
    do @(posedge clk_i); while (busy_o);
    sched_sb.note_tick(av, pri, len);
    n_ticks++;
    @(negedge clk_i);
    start_i = 0;
  endtask

  // random tick: mostly short jobs, some idle ticks, a few long ones
  task automatic random_tick(int arr_pct);
    bit [15:0] len;
    case ($urandom_range(0, 9))
      0:       len = 16'($urandom);
      1:       len = 16'd0;
      default: len = 16'($urandom_range(1, 20));
    endcase
    send_tick($urandom_range(0, 99) < arr_pct, 4'($urandom), len);
  endtask

  initial begin
    bit [3:0] lvl_set [5] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3};
    sched_sb = new();
    quiet_sender = 0; n_ticks = 0;
    rst_ni = 0; start_i = 0; arrival_valid_i = 0; job_priority_i = 0; job_length_i = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    drain();

    // directed: idle tick, extremes, ties at one priority, zero length
    send_tick(0, 0, 0);
    send_tick(1, 4'd15, 16'hFFFF);
    send_tick(1, 4'd0, 16'd1);
    send_tick(1, 4'd0, 16'd0);
    send_tick(1, 4'd5, 16'd9);
    send_tick(1, 4'd5, 16'd9);
    send_tick(1, 4'd5, 16'd3);
    send_tick(1, 4'd10, 16'h5555);
    send_tick(1, 4'd1, 16'hAAAA);
    for (int i = 0; i < 12; i++) send_tick(0, 0, 0);
    drain();

    // store fill: many arrivals with long jobs to force drops
    write_levels(4'd2);
    for (int i = 0; i < 75; i++) send_tick(1, 4'($urandom), 16'($urandom_range(50, 200)));
    drain();

    // shrink the level count while jobs sit at higher levels
    write_levels(4'd8);
    for (int i = 0; i < 40; i++) random_tick(70);
    drain();
    write_levels(4'd1);
    for (int i = 0; i < 40; i++) random_tick(30);
    drain();

    // random phases across level settings
    foreach (lvl_set[k]) begin
      write_levels(lvl_set[k]);
      for (int i = 0; i < 250; i++) random_tick((k % 2) ? 60 : 25);
      drain();
    end
    write_levels(4'($urandom_range(1, 8)));
    quiet_sender = 1;
    for (int i = 0; i < 150; i++) random_tick(40);
    drain();

    $display("Ran %0d ticks over level counts 0..15: %0d jobs finished, %0d dropped, %0d idle",
             n_ticks, sched_sb.n_done, sched_sb.n_drop, sched_sb.n_idle_words);
    if (sched_sb.errors == 0 && sched_sb.pending_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
